/* hw/rtl/bspt_pkg.sv */
// Package for the bus sync phase tracker: event codes, register indexes,
// field widths and the transaction payload types.
// No dependencies; every other file of the block imports it.
package bspt_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned SeqW    = 16;
  localparam int unsigned WinW    = 20;
  localparam int unsigned CountW  = 32;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 32;

  localparam logic [TimeW-1:0] TimeoutReset = 32'd5000;

  typedef enum logic [1:0] {
    FUNC_TICK      = 2'd0,
    FUNC_SYNC_RX   = 2'd1,
    FUNC_MASTER_TX = 2'd2,
    FUNC_STATS_CLR = 2'd3
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MASTER_MODE   = 1'd0,
    CFG_TIMEOUT_LIMIT = 1'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]       func;
    logic [TimeW-1:0] now_us;
    logic [TimeW-1:0] frame_timestamp_us;
    logic [SeqW-1:0]  frame_sequence;
    logic [WinW-1:0]  window_phase_us;
    logic [WinW-1:0]  window_tolerance_us;
  } in_t;

  typedef struct packed {
    logic              is_synced;
    logic              timed_out;
    logic              sync_event;
    logic [WinW-1:0]   captured_phase_us;
    logic [WinW-1:0]   current_phase_us;
    logic              in_window;
    logic              phase_reached;
    logic [CountW-1:0] missed_total;
    logic [CountW-1:0] sync_total;
    logic              tx_valid;
    logic [TimeW-1:0]  tx_timestamp_us;
    logic [SeqW-1:0]   tx_sequence;
  } out_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] reg_index;
    logic [CfgW-1:0]    wdata;
  } cfg_t;

  // Per-item results that are final at acceptance and ride along the
  // phase pipeline until the output register.
  typedef struct packed {
    logic              synced;
    logic              timed_out;
    logic              sync_event;
    logic [CountW-1:0] missed_total;
    logic [CountW-1:0] sync_total;
    logic              tx_valid;
    logic [TimeW-1:0]  tx_timestamp_us;
    logic [SeqW-1:0]   tx_sequence;
    logic [WinW-1:0]   win_lo;
    logic [WinW:0]     win_hi;
    logic [WinW-1:0]   target;
  } info_t;

endpackage

/* hw/rtl/bspt_if.sv */
// Valid/ready channel interfaces of the bus sync phase tracker: input items,
// result items and configuration writes. Depends on bspt_pkg.

interface bspt_in_if import bspt_pkg::*; ();
  logic valid;
  logic ready;
  in_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bspt_out_if import bspt_pkg::*; ();
  logic valid;
  logic ready;
  out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bspt_cfg_if import bspt_pkg::*; ();
  logic valid;
  logic ready;
  cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/bus_sync_phase_tracker_top.sv */
// Top level of the bus sync phase tracker.
// Depends on bspt_pkg and the channel interfaces in bspt_if.sv.

// The tracker takes one transaction per clock cycle unless a stalled result
// side has filled the pipeline, and returns exactly one result transaction
// for each. All tracker state (sync flag, last sync time, last
// sequence number, counters) is updated in the cycle of acceptance, so an
// item that follows in the very next cycle sees the effect of the one before
// it. The latency is set by the phase path: the elapsed time modulo the sync
// period is formed by a reciprocal multiply, a back multiply with subtract
// and a pair of conditional subtractions, each of these three in a stage of
// its own, and the window compares sit in front of the output register. The
// pipeline compresses bubbles, so new transactions are still taken while a
// finished result waits at the output. Configuration writes are always
// accepted; they take effect for items accepted afterwards and are meant to
// be issued while the tracker is idle.
module bus_sync_phase_tracker_top import bspt_pkg::*; #(
  parameter int unsigned PeriodUs = 1000
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bspt_in_if.sink     in_i,
  bspt_out_if.source  out_o,
  bspt_cfg_if.sink    cfg_i
);

  // Phase arithmetic widths. The reciprocal is floor(2^RecipShift / period),
  // which stays below 2^32; the quotient estimate it gives is short by at
  // most two, so the first remainder stays below three periods.
  localparam int unsigned PhaseW     = (PeriodUs > 1) ? $clog2(PeriodUs) : 1;
  localparam int unsigned RemW       = $clog2(3 * PeriodUs);
  localparam int unsigned RecipShift = 31 + ((PeriodUs > 1) ? $clog2(PeriodUs) : 0);
  localparam logic [63:0] RecipFull  = (64'd1 << RecipShift) / 64'(PeriodUs);
  localparam logic [31:0] Recip      = 32'(RecipFull);
  localparam int unsigned Stages     = 4;
  localparam int unsigned NumLanes   = 2;
  localparam int unsigned LaneCur    = 0;
  localparam int unsigned LaneHeld   = 1;

  // Configuration registers.
  logic             master_q;
  logic [TimeW-1:0] limit_q;

  // Tracker state.
  logic              synced_q, synced_d;
  logic [TimeW-1:0]  last_time_q, last_time_d;
  logic [SeqW-1:0]   last_seq_q, last_seq_d;
  logic [CountW-1:0] sync_cnt_q, sync_cnt_d;
  logic [CountW-1:0] missed_q, missed_d;
  logic [PhaseW-1:0] held_q;

  // Pipeline control and payload.
  logic [Stages:0]   ld;
  logic [Stages-1:0] vld_q;
  logic              out_valid_q;
  out_t              out_q, out_d;
  info_t             info_q [Stages];
  info_t             info_d;
  logic              in_fire;

  logic [TimeW-1:0]  s1_x_q    [NumLanes];
  logic [TimeW-1:0]  s1_x_d    [NumLanes];
  logic [63:0]       s2_prod_q [NumLanes];
  logic [TimeW-1:0]  s2_x_q    [NumLanes];
  logic [RemW-1:0]   s3_rem_q  [NumLanes];
  logic [RemW-1:0]   s3_rem_d  [NumLanes];
  logic [PhaseW-1:0] s4_ph_q   [NumLanes];
  logic [PhaseW-1:0] s4_ph_d   [NumLanes];

  // Configuration port.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      master_q <= 1'b0;
      limit_q  <= TimeoutReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.reg_index)
        CFG_MASTER_MODE:   master_q <= cfg_i.data.wdata[0];
        CFG_TIMEOUT_LIMIT: limit_q  <= cfg_i.data.wdata;
        default: ;
      endcase
    end
  end

  // Load enables. A stage loads when it is empty or the stage after it
  // moves on, so a stalled output only stops the items behind it once the
  // pipeline has filled up.
  always_comb begin
    ld[Stages] = !out_valid_q || out_o.ready;
    for (int k = Stages - 1; k >= 0; k--) begin
      ld[k] = !vld_q[k] || ld[k+1];
    end
  end

  assign in_i.ready = ld[0];
  assign in_fire    = in_i.valid && ld[0];

  // Event handling and timeout check, all at acceptance.
  always_comb begin
    logic             is_rx, is_tx, is_clr, count_gap, synced_evt, timeout;
    logic [SeqW-1:0]  expected, gap;
    logic [TimeW-1:0] elapsed;
    logic [WinW-1:0]  target, tol;

    is_rx  = (in_i.data.func == FUNC_SYNC_RX) && !master_q;
    is_tx  = (in_i.data.func == FUNC_MASTER_TX) && master_q;
    is_clr = (in_i.data.func == FUNC_STATS_CLR);

    // A gap with the top bit set is a late or repeated frame, not a loss.
    expected  = last_seq_q + SeqW'(1);
    gap       = in_i.data.frame_sequence - expected;
    count_gap = synced_q && (gap != '0) && !gap[SeqW-1];

    missed_d   = missed_q;
    sync_cnt_d = sync_cnt_q;
    last_time_d = last_time_q;
    last_seq_d = last_seq_q;
    if (is_rx) begin
      if (count_gap) begin
        missed_d = missed_q + CountW'(gap);
      end
      sync_cnt_d  = sync_cnt_q + CountW'(1);
      last_time_d = in_i.data.now_us;
      last_seq_d  = in_i.data.frame_sequence;
    end else if (is_tx) begin
      sync_cnt_d  = sync_cnt_q + CountW'(1);
      last_time_d = in_i.data.now_us;
    end else if (is_clr) begin
      sync_cnt_d = '0;
      missed_d   = '0;
    end

    // A step that just synced has zero elapsed time and cannot time out.
    synced_evt = synced_q || is_rx || is_tx;
    elapsed    = in_i.data.now_us - last_time_d;
    timeout    = synced_evt && (elapsed > limit_q);
    synced_d   = synced_evt && !timeout;

    s1_x_d[LaneCur]  = elapsed;
    s1_x_d[LaneHeld] = in_i.data.now_us - in_i.data.frame_timestamp_us;

    target = in_i.data.window_phase_us;
    tol    = in_i.data.window_tolerance_us;

    info_d.synced          = synced_d;
    info_d.timed_out       = timeout;
    info_d.sync_event      = is_rx;
    info_d.missed_total    = missed_d;
    info_d.sync_total      = sync_cnt_d;
    info_d.tx_valid        = is_tx;
    info_d.tx_timestamp_us = is_tx ? in_i.data.now_us : '0;
    info_d.tx_sequence     = is_tx ? sync_cnt_q[SeqW-1:0] : '0;
    info_d.win_lo          = (target >= tol) ? (target - tol) : '0;
    info_d.win_hi          = {1'b0, target} + {1'b0, tol};
    info_d.target          = target;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      synced_q    <= 1'b0;
      last_time_q <= '0;
      last_seq_q  <= '0;
      sync_cnt_q  <= '0;
      missed_q    <= '0;
    end else if (in_fire) begin
      synced_q    <= synced_d;
      last_time_q <= last_time_d;
      last_seq_q  <= last_seq_d;
      sync_cnt_q  <= sync_cnt_d;
      missed_q    <= missed_d;
    end
  end

  // Valid bits of the pipeline and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ld[0]) begin
        vld_q[0] <= in_i.valid;
      end
      for (int k = 1; k < Stages; k++) begin
        if (ld[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
      if (ld[Stages]) begin
        out_valid_q <= vld_q[Stages-1];
      end
    end
  end

  // Modulo pipeline: remainder after the estimated quotient, then the
  // two corrections that bring it below one period.
  always_comb begin
    logic [TimeW-1:0] quot;
    logic [RemW-1:0]  r1;
    for (int l = 0; l < NumLanes; l++) begin
      quot        = 32'(s2_prod_q[l] >> RecipShift);
      s3_rem_d[l] = RemW'(s2_x_q[l] - quot * 32'(PeriodUs));
      r1          = (s3_rem_q[l] >= RemW'(PeriodUs)) ? s3_rem_q[l] - RemW'(PeriodUs)
                                                     : s3_rem_q[l];
      s4_ph_d[l]  = (r1 >= RemW'(PeriodUs)) ? PhaseW'(r1 - RemW'(PeriodUs))
                                            : PhaseW'(r1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      info_q[0] <= info_d;
      s1_x_q    <= s1_x_d;
    end
    if (ld[1]) begin
      info_q[1] <= info_q[0];
      for (int l = 0; l < NumLanes; l++) begin
        s2_prod_q[l] <= 64'(s1_x_q[l]) * 64'(Recip);
        s2_x_q[l]    <= s1_x_q[l];
      end
    end
    if (ld[2]) begin
      info_q[2] <= info_q[1];
      s3_rem_q  <= s3_rem_d;
    end
    if (ld[3]) begin
      info_q[3] <= info_q[2];
      s4_ph_q   <= s4_ph_d;
    end
  end

  // Output stage: window tests and the captured phase. The captured phase
  // changes only when an accepted sync frame passes this point, which keeps
  // it in item order with everything else.
  always_comb begin
    logic [WinW:0]     ph;
    logic              syn;
    logic [PhaseW-1:0] cap;
    syn = info_q[Stages-1].synced;
    ph  = syn ? (WinW+1)'(s4_ph_q[LaneCur]) : '0;
    cap = info_q[Stages-1].sync_event ? s4_ph_q[LaneHeld] : held_q;

    out_d.is_synced         = syn;
    out_d.timed_out         = info_q[Stages-1].timed_out;
    out_d.sync_event        = info_q[Stages-1].sync_event;
    out_d.captured_phase_us = WinW'(cap);
    out_d.current_phase_us  = WinW'(ph);
    out_d.in_window         = syn && (ph >= {1'b0, info_q[Stages-1].win_lo})
                                  && (ph <= info_q[Stages-1].win_hi);
    out_d.phase_reached     = syn && (ph >= {1'b0, info_q[Stages-1].target});
    out_d.missed_total      = info_q[Stages-1].missed_total;
    out_d.sync_total        = info_q[Stages-1].sync_total;
    out_d.tx_valid          = info_q[Stages-1].tx_valid;
    out_d.tx_timestamp_us   = info_q[Stages-1].tx_timestamp_us;
    out_d.tx_sequence       = info_q[Stages-1].tx_sequence;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (ld[Stages] && vld_q[Stages-1] && info_q[Stages-1].sync_event) begin
      held_q <= s4_ph_q[LaneHeld];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[Stages]) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

/* hw/rtl/bspt_checker.sv */
// Port-level checker for the bus sync phase tracker result channel, and the
// bind that attaches it to bus_sync_phase_tracker_top. Depends on bspt_pkg.
module bspt_checker import bspt_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_i,
  input logic out_ready_i,
  input out_t out_data_i
);

  // A result held back by the consumer must not change.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("result changed while stalled");

  // An accepted sync frame leaves the tracker synchronized and sends nothing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.sync_event |->
      out_data_i.is_synced && !out_data_i.timed_out && !out_data_i.tx_valid)
    else $error("sync frame result inconsistent");

  // A transmitted frame means the master just synced itself.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.tx_valid |->
      out_data_i.is_synced && !out_data_i.timed_out)
    else $error("transmit result inconsistent");

  // Timeout drops synchronization.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.timed_out |-> !out_data_i.is_synced)
    else $error("timeout left tracker synchronized");

  // Without synchronization the phase and window results are all zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.is_synced |->
      (out_data_i.current_phase_us == '0) && !out_data_i.in_window &&
      !out_data_i.phase_reached)
    else $error("phase reported while not synchronized");

endmodule

bind bus_sync_phase_tracker_top bspt_checker u_bspt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

/* test/bus_sync_phase_tracker_top_tb.sv */
// Self-checking testbench for bus_sync_phase_tracker_top: directed and random event
// streams, with a scoreboard class that tracks sync state and checks every result.
// Depends on bspt_pkg and the channel interfaces in bspt_if.sv.
`timescale 1ns / 100ps

module bus_sync_phase_tracker_top_tb;
  import bspt_pkg::*;

  localparam int unsigned PeriodUs = 1000;

  // The scoreboard keeps its own copy of the tracker state and registers. Every
  // accepted input transaction advances that state and leaves one expected
  // report behind; result transactions are matched against them in order.
  class sync_tracker_shadow;
    logic              master_mode;
    logic [TimeW-1:0]  timeout_limit;
    logic              synced;
    logic [TimeW-1:0]  last_sync_us;
    logic [SeqW-1:0]   last_seq;
    logic [CountW-1:0] sync_tally;
    logic [CountW-1:0] missed_tally;
    logic [WinW-1:0]   held_phase;
    out_t              due_reports[$];
    int unsigned       errors;

    function new();
      master_mode   = 1'b0;
      timeout_limit = TimeoutReset;
      synced        = 1'b0;
      last_sync_us  = '0;
      last_seq      = '0;
      sync_tally    = '0;
      missed_tally  = '0;
      held_phase    = '0;
      errors        = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CfgW-1:0] value);
      case (idx)
        CFG_MASTER_MODE:   master_mode = value[0];
        CFG_TIMEOUT_LIMIT: timeout_limit = value;
        default: ;
      endcase
    endfunction

    // Handles the event, then the timeout check, then the phase and window tests.
    function out_t advance_tracker(in_t item);
      out_t             r;
      logic [SeqW-1:0]  gap;
      logic [TimeW-1:0] elapsed;
      logic [WinW-1:0]  phase;
      logic [WinW-1:0]  lo;
      logic [WinW:0]    hi;
      r = '0;
      case (item.func)
        FUNC_SYNC_RX: begin
          if (!master_mode) begin
            // Only a forward gap counts; bit 15 set means a late or repeated frame.
            if (synced) begin
              gap = item.frame_sequence - (last_seq + 16'd1);
              if (gap != '0 && !gap[SeqW-1]) missed_tally = missed_tally + CountW'(gap);
            end
            held_phase   = WinW'((item.now_us - item.frame_timestamp_us) % PeriodUs);
            last_sync_us = item.now_us;
            last_seq     = item.frame_sequence;
            sync_tally   = sync_tally + CountW'(1);
            synced       = 1'b1;
            r.sync_event = 1'b1;
          end
        end
        FUNC_MASTER_TX: begin
          if (master_mode) begin
            r.tx_valid        = 1'b1;
            r.tx_timestamp_us = item.now_us;
            r.tx_sequence     = sync_tally[SeqW-1:0];
            sync_tally        = sync_tally + CountW'(1);
            last_sync_us      = item.now_us;
            synced            = 1'b1;
          end
        end
        FUNC_STATS_CLR: begin
          sync_tally   = '0;
          missed_tally = '0;
        end
        default: ;
      endcase

      elapsed = item.now_us - last_sync_us;
      if (synced && elapsed > timeout_limit) begin
        synced      = 1'b0;
        r.timed_out = 1'b1;
      end

      if (synced) begin
        // Lower bound clamps at zero; the upper bound keeps its carry.
        lo    = (item.window_phase_us >= item.window_tolerance_us) ?
                item.window_phase_us - item.window_tolerance_us : '0;
        hi    = {1'b0, item.window_phase_us} + {1'b0, item.window_tolerance_us};
        phase = WinW'(elapsed % PeriodUs);
        r.current_phase_us = phase;
        r.in_window        = (phase >= lo) && ({1'b0, phase} <= hi);
        r.phase_reached    = (phase >= item.window_phase_us);
      end

      r.is_synced         = synced;
      r.captured_phase_us = held_phase;
      r.missed_total      = missed_tally;
      r.sync_total        = sync_tally;
      return r;
    endfunction

    function void note_item(in_t item);
      due_reports.push_back(advance_tracker(item));
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_report(out_t got);
      out_t want;
      if (due_reports.size() == 0) begin
        $display("%0t: result transaction with none pending, actual %h", $time, got);
        errors++;
        return;
      end
      want = due_reports.pop_front();
      compare("is_synced", want.is_synced, got.is_synced);
      compare("timed_out", want.timed_out, got.timed_out);
      compare("sync_event", want.sync_event, got.sync_event);
      compare("captured_phase_us", want.captured_phase_us, got.captured_phase_us);
      compare("current_phase_us", want.current_phase_us, got.current_phase_us);
      compare("in_window", want.in_window, got.in_window);
      compare("phase_reached", want.phase_reached, got.phase_reached);
      compare("missed_total", want.missed_total, got.missed_total);
      compare("sync_total", want.sync_total, got.sync_total);
      compare("tx_valid", want.tx_valid, got.tx_valid);
      compare("tx_timestamp_us", want.tx_timestamp_us, got.tx_timestamp_us);
      compare("tx_sequence", want.tx_sequence, got.tx_sequence);
    endfunction
  endclass

  logic clk;
  logic rst_n;

  bspt_in_if  in_if ();
  bspt_out_if out_if ();
  bspt_cfg_if cfg_if ();

  bus_sync_phase_tracker_top #(
    .PeriodUs(PeriodUs)
  ) i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  sync_tracker_shadow sb = new();

  // Events waiting to be sent, plus the cursors that keep random streams
  // well formed: a running local time and the last sequence number sent.
  in_t              pending_events[$];
  logic [TimeW-1:0] now_cursor;
  logic [SeqW-1:0]  seq_cursor;
  bit               sender_steady;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: the ready pattern is chosen anew at regular intervals among
  // always ready, random stalls, a sparse pulse train and long stall stretches.
  initial begin : result_sink
    int unsigned cyc;
    int unsigned pattern;
    cyc = 0;
    pattern = 0;
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (cyc % 40 == 0) pattern = $urandom_range(3);
      case (pattern)
        0: out_if.ready = 1'b1;
        1: out_if.ready = ($urandom_range(3) != 0);
        2: out_if.ready = (cyc % 3 == 0);
        default: out_if.ready = ((cyc % 16) < 10);
      endcase
      cyc++;
    end
  end

  // Every result transaction is checked at the rising edge that accepts it.
  always @(posedge clk) begin
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      sb.check_report(out_if.data);
    end
  end

  function automatic void queue_event(func_e f, logic [TimeW-1:0] now,
                                      logic [TimeW-1:0] fts, logic [SeqW-1:0] seq,
                                      logic [WinW-1:0] target, logic [WinW-1:0] tol);
    in_t it;
    it.func                = f;
    it.now_us              = now;
    it.frame_timestamp_us  = fts;
    it.frame_sequence      = seq;
    it.window_phase_us     = target;
    it.window_tolerance_us = tol;
    pending_events.push_back(it);
  endfunction

  // Mostly well-formed traffic for the current role: time moves forward in
  // small steps with an occasional jump past the timeout, and sequence numbers
  // mostly run on by one. About a tenth of the items are pure noise.
  function automatic in_t random_item(bit as_master);
    in_t         it;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) begin
      it.func                = 2'($urandom_range(3));
      it.now_us              = $urandom;
      it.frame_timestamp_us  = $urandom;
      it.frame_sequence      = 16'($urandom_range(16'hFFFF));
      it.window_phase_us     = 20'($urandom_range(20'hFFFFF));
      it.window_tolerance_us = 20'($urandom_range(20'hFFFFF));
      return it;
    end
    now_cursor = now_cursor + ((roll < 16) ? $urandom_range(1000, 12000) :
                                             $urandom_range(0, 400));
    it.now_us = now_cursor;
    it.frame_timestamp_us = ($urandom_range(9) == 0) ? $urandom :
                            now_cursor - $urandom_range(0, 2999);
    if ($urandom_range(9) < 8) begin
      it.window_phase_us     = 20'($urandom_range(PeriodUs - 1));
      it.window_tolerance_us = 20'($urandom_range(300));
    end else begin
      it.window_phase_us     = 20'($urandom_range(20'hFFFFF));
      it.window_tolerance_us = 20'($urandom_range(20'hFFFFF));
    end

    roll = $urandom_range(99);
    if (roll < 35)      it.func = as_master ? FUNC_MASTER_TX : FUNC_SYNC_RX;
    else if (roll < 45) it.func = as_master ? FUNC_SYNC_RX : FUNC_MASTER_TX;
    else if (roll < 50) it.func = FUNC_STATS_CLR;
    else                it.func = FUNC_TICK;

    roll = $urandom_range(99);
    if (roll < 75)      it.frame_sequence = seq_cursor + 16'd1;
    else if (roll < 85) it.frame_sequence = seq_cursor + 16'($urandom_range(2, 6));
    else if (roll < 92) it.frame_sequence = seq_cursor - 16'($urandom_range(0, 3));
    else                it.frame_sequence = 16'($urandom_range(16'hFFFF));
    if (it.func == FUNC_SYNC_RX) seq_cursor = it.frame_sequence;
    return it;
  endfunction

  // Sends the queued events in bursts of random length. Valid stays high
  // across a burst; between bursts it may drop for a random number of cycles,
  // but never while the current phase runs the sender without gaps.
  task automatic drive_items();
    in_t         item;
    int unsigned burst_left;
    int unsigned gap;
    burst_left = 0;
    while (pending_events.size() != 0) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = (sender_steady || $urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          in_if.valid = 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      item = pending_events.pop_front();
      in_if.valid = 1'b1;
      in_if.data  = item;
      do @(posedge clk); while (in_if.ready !== 1'b1);
      sb.note_item(item);
      burst_left--;
      @(negedge clk);
    end
    in_if.valid = 1'b0;
  endtask

  // Every item yields a result, so the tracker is idle once nothing is
  // pending; a few more cycles cover the tail of the pipeline.
  task automatic wait_idle();
    while (sb.due_reports.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgW-1:0] value);
    cfg_if.valid          = 1'b1;
    cfg_if.data.reg_index = idx;
    cfg_if.data.wdata     = value;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    sb.write_reg(idx, value);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  initial begin : stimulus
    logic [CfgW-1:0] limit;
    in_if.valid   = 1'b0;
    in_if.data    = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.data   = '0;
    sender_steady = 1'b0;
    now_cursor    = '0;
    seq_cursor    = '0;
    rst_n         = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part, slave role with the reset timeout of 5000 us. A tick
    // before any sync reports nothing, even with every window field at max;
    // a send request is ignored in the wrong role.
    queue_event(FUNC_TICK, 32'd0, 32'hFFFF_FFFF, 16'hFFFF, 20'hFFFFF, 20'hFFFFF);
    queue_event(FUNC_MASTER_TX, 32'd10, 32'd0, 16'd0, 20'd0, 20'd0);
    // First frame: no gap can count while unsynchronized.
    queue_event(FUNC_SYNC_RX, 32'd1000, 32'd0, 16'hFFFF, 20'd0, 20'd0);
    // Sequence wraps from 0xFFFF to 0 without a gap.
    queue_event(FUNC_SYNC_RX, 32'd2000, 32'd1250, 16'd0, 20'd500, 20'd10);
    // Forward gap of four frames.
    queue_event(FUNC_SYNC_RX, 32'd3000, 32'd2877, 16'd5, 20'd100, 20'd50);
    // Late frame: the negative gap is not counted.
    queue_event(FUNC_SYNC_RX, 32'd4000, 32'd4000, 16'd3, 20'd0, 20'd0);
    // Largest countable gap, with the master timestamp just ahead of local time.
    queue_event(FUNC_SYNC_RX, 32'd5000, 32'd5001, 16'd32771, 20'd0, 20'd0);
    // Gap of exactly 0x8000 has bit 15 set and is not counted.
    queue_event(FUNC_SYNC_RX, 32'd6000, 32'd0, 16'd4, 20'd0, 20'd0);
    // Lower window bound clamps at zero.
    queue_event(FUNC_TICK, 32'd6400, 32'd0, 16'd0, 20'd100, 20'd300);
    // Upper window bound beyond 20 bits does not wrap.
    queue_event(FUNC_TICK, 32'd6401, 32'd0, 16'd0, 20'hFFFFF, 20'hFFFFF);
    queue_event(FUNC_TICK, 32'd6999, 32'd0, 16'd0, 20'd999, 20'd0);
    // Elapsed equal to the limit keeps sync; one more microsecond drops it.
    queue_event(FUNC_TICK, 32'd11000, 32'd0, 16'd0, 20'd0, 20'd0);
    queue_event(FUNC_TICK, 32'd11001, 32'd0, 16'd0, 20'd0, 20'd0);
    queue_event(FUNC_STATS_CLR, 32'd11002, 32'd0, 16'd0, 20'd0, 20'd0);
    // Resync near the top of the time range, then a tick after the wrap.
    queue_event(FUNC_SYNC_RX, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 16'h1234, 20'd0, 20'd0);
    queue_event(FUNC_TICK, 32'h0000_0010, 32'd0, 16'd0, 20'd32, 20'd0);
    drive_items();
    wait_idle();

    // Master role with a zero timeout: a received frame is ignored and the
    // stale sync times out in the same step.
    write_reg(CFG_MASTER_MODE, 32'd1);
    write_reg(CFG_TIMEOUT_LIMIT, 32'd0);
    queue_event(FUNC_SYNC_RX, 32'd100, 32'd0, 16'h8000, 20'd0, 20'd0);
    queue_event(FUNC_MASTER_TX, 32'd200, 32'd0, 16'd0, 20'd0, 20'd0);
    queue_event(FUNC_TICK, 32'd200, 32'd0, 16'd0, 20'd0, 20'd0);
    queue_event(FUNC_TICK, 32'd201, 32'd0, 16'd0, 20'd0, 20'd0);
    drive_items();
    wait_idle();

    // Largest timeout: sync holds across half the time range.
    write_reg(CFG_TIMEOUT_LIMIT, 32'hFFFF_FFFF);
    queue_event(FUNC_MASTER_TX, 32'hFFFF_FFFF, 32'd0, 16'd0, 20'd0, 20'd0);
    queue_event(FUNC_TICK, 32'h7FFF_FFFF, 32'd0, 16'd0, 20'd647, 20'd0);
    queue_event(FUNC_STATS_CLR, 32'h8000_0000, 32'd0, 16'd0, 20'd500, 20'd500);
    queue_event(FUNC_MASTER_TX, 32'h8000_0001, 32'd0, 16'd0, 20'd0, 20'd0);
    drive_items();
    wait_idle();

    // Random part: eight phases of 50 items, each with its own role and
    // timeout. One phase runs the sender without gaps, and one starts the
    // time cursor just below the wrap.
    now_cursor = $urandom;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: limit = 32'd5000;
        1: limit = 32'd0;
        2: limit = 32'd1500;
        3: limit = 32'hFFFF_FFFF;
        4: limit = $urandom;
        5: limit = 32'd2500;
        6: limit = $urandom_range(300);
        default: limit = TimeoutReset;
      endcase
      write_reg(CFG_MASTER_MODE, (p < 6) ? p % 2 : $urandom_range(1));
      write_reg(CFG_TIMEOUT_LIMIT, limit);
      sender_steady = (p == 3);
      if (p == 5) now_cursor = 32'hFFFF_F000;
      for (int n = 0; n < 50; n++) pending_events.push_back(random_item(sb.master_mode));
      drive_items();
      wait_idle();
    end

    // Drain: nothing pending, then a quiet stretch to catch stray results.
    while (sb.due_reports.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (sb.errors == 0 && sb.due_reports.size() == 0) begin
      $display("bus_sync_phase_tracker_top_tb: done, clean");
    end else begin
      $display("bus_sync_phase_tracker_top_tb: done, errors");
    end
    $finish;
  end

  // Watchdog: a correct run needs well under a tenth of this time.
  initial begin : watchdog
    #5_000_000;
    $display("bus_sync_phase_tracker_top_tb: done, errors");
    $finish;
  end

endmodule
